/* rtl/icwts_pkg.sv */
// ----------------------------------------------------------------------------
// icwts_pkg
// Shared opcodes and choice codes for the idle cpu wake target selector.
// ----------------------------------------------------------------------------
package icwts_pkg;

    localparam int OPCODE_W = 3;
    localparam int CPU_ID_W = 3;
    localparam int PREF_W   = 8;
    localparam int KIND_W   = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_IDLE_ENTER = 3'd0,
        OP_IDLE_EXIT  = 3'd1,
        OP_ENQUEUE    = 3'd2,
        OP_DEQUEUE    = 3'd3,
        OP_SELECT     = 3'd4
    } t_opcode;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE = 2'd0,
        KIND_PREV = 2'd1,
        KIND_SYNC = 2'd2,
        KIND_ANY  = 2'd3
    } t_choice_kind;

endpackage

/* rtl/idle_cpu_wake_target_selector.sv */
// ----------------------------------------------------------------------------
// idle_cpu_wake_target_selector
// Idle cpu tracking, per-cpu queued task counters and wake target selection.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel i_valid / o_stall carries one event or select request.
//   Opcodes idle enter, idle exit, enqueue and dequeue update state and give
//   no result; a select request gives exactly one result on o_valid / i_stall.
//   A request is registered on acceptance and resolved from the input register
//   by one priority encode over the idle and preferred masks plus a counter
//   compare; the result register then holds it. One request is accepted
//   every cycle while o_stall is low.
//   When the result register is full and i_stall is high, a select request in
//   the input register waits and o_stall rises; event requests still drain.
//   i_select_enable_we writes the select enable bit; write it while idle.
//   Synchronous active-low reset clears idle bits, counters, the enable bit
//   and both valid flags; no cpu is idle and no request is held after reset.
// ----------------------------------------------------------------------------
module idle_cpu_wake_target_selector
    import icwts_pkg::*;
#(
    parameter int NUM_CPUS    = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_select_enable_we,
    input  logic                i_select_enable,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [CPU_ID_W-1:0] i_cpu_id,
    input  logic [PREF_W-1:0]   i_preferred_set,
    input  logic [CPU_ID_W-1:0] i_previous_cpu,
    input  logic                i_single_cpu_only,
    input  logic                i_wake_sync,
    input  logic                i_waker_exiting,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_target_valid,
    output logic [CPU_ID_W-1:0] o_wake_cpu,
    output logic [KIND_W-1:0]   o_choice_kind
);

    // only cpus reachable through a 3-bit id are tracked
    localparam int SEL_CPUS = (NUM_CPUS < (1 << CPU_ID_W)) ? NUM_CPUS : (1 << CPU_ID_W);
    localparam int SEL_IDX_W = $clog2(SEL_CPUS);
    localparam logic [CPU_ID_W:0] SEL_CPUS_V = (CPU_ID_W+1)'(SEL_CPUS);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic                   r_enable;
    logic [SEL_CPUS-1:0]    r_idle;
    logic [COUNT_WIDTH-1:0] r_count [SEL_CPUS];

    logic                r_in_vld;
    logic [OPCODE_W-1:0] r_opcode;
    logic [CPU_ID_W-1:0] r_cpu;
    logic [PREF_W-1:0]   r_pref;
    logic [CPU_ID_W-1:0] r_prev;
    logic                r_single;
    logic                r_sync;
    logic                r_exiting;

    logic                r_out_vld;
    logic                r_tgt_vld;
    logic [CPU_ID_W-1:0] r_tgt_cpu;
    t_choice_kind        r_kind;

    logic                in_accept;
    logic                is_select;
    logic                stage_adv;
    logic                out_free;
    logic                cpu_ok;
    logic                prev_ok;
    logic [SEL_IDX_W-1:0] cpu_idx;
    logic [SEL_IDX_W-1:0] prev_idx;
    logic [SEL_CPUS-1:0] pref_v;
    logic [SEL_CPUS-1:0] cand;
    logic [CPU_ID_W-1:0] any_idx;
    logic                prev_hit;
    logic                sync_hit;
    logic [COUNT_WIDTH-1:0] cnt_cur;

    logic [SEL_CPUS-1:0]    n_idle;
    logic                   n_cnt_we;
    logic [COUNT_WIDTH-1:0] n_cnt;
    logic                   n_tgt_vld;
    logic [CPU_ID_W-1:0]    n_tgt_cpu;
    t_choice_kind           n_kind;

    assign is_select = (r_opcode == OP_SELECT);
    assign out_free  = !r_out_vld || !i_stall;
    assign stage_adv = r_in_vld && (!is_select || out_free);
    assign o_stall   = r_in_vld && !stage_adv;
    assign in_accept = i_valid && !o_stall;

    assign cpu_ok   = {1'b0, r_cpu} < SEL_CPUS_V;
    assign prev_ok  = {1'b0, r_prev} < SEL_CPUS_V;
    assign cpu_idx  = r_cpu[SEL_IDX_W-1:0];
    assign prev_idx = r_prev[SEL_IDX_W-1:0];
    assign pref_v   = r_pref[SEL_CPUS-1:0];
    assign cand     = pref_v & r_idle;
    assign cnt_cur  = r_count[cpu_idx];

    always_comb begin
        any_idx = '0;
        for (int i = SEL_CPUS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                any_idx = CPU_ID_W'(i);
            end
        end
    end

    assign prev_hit = prev_ok && pref_v[prev_idx] && r_idle[prev_idx];
    assign sync_hit = r_sync && !r_exiting && cpu_ok && (cnt_cur == '0) && pref_v[cpu_idx];

    always_comb begin
        n_idle    = r_idle;
        n_cnt_we  = 1'b0;
        n_cnt     = cnt_cur;
        n_tgt_vld = 1'b0;
        n_tgt_cpu = '0;
        n_kind    = KIND_NONE;
        case (r_opcode)
            OP_IDLE_ENTER: begin
                if (cpu_ok) begin
                    n_idle[cpu_idx] = 1'b1;
                end
            end
            OP_IDLE_EXIT: begin
                if (cpu_ok) begin
                    n_idle[cpu_idx] = 1'b0;
                end
            end
            OP_ENQUEUE: begin
                if (cpu_ok && cnt_cur != COUNT_MAX) begin
                    n_cnt_we = 1'b1;
                    n_cnt    = cnt_cur + 1'b1;
                end
            end
            OP_DEQUEUE: begin
                if (cpu_ok && cnt_cur != '0) begin
                    n_cnt_we = 1'b1;
                    n_cnt    = cnt_cur - 1'b1;
                end
            end
            OP_SELECT: begin
                if (r_enable) begin
                    if (prev_hit) begin
                        n_idle[prev_idx] = 1'b0;
                        n_tgt_vld        = 1'b1;
                        n_tgt_cpu        = r_prev;
                        n_kind           = KIND_PREV;
                    end else if (r_single) begin
                        n_tgt_vld = 1'b0;
                    end else if (sync_hit) begin
                        n_tgt_vld = 1'b1;
                        n_tgt_cpu = r_cpu;
                        n_kind    = KIND_SYNC;
                    end else if (cand != '0) begin
                        n_idle[any_idx[SEL_IDX_W-1:0]] = 1'b0;
                        n_tgt_vld = 1'b1;
                        n_tgt_cpu = any_idx;
                        n_kind    = KIND_ANY;
                    end
                end
            end
            default: begin
                n_idle = r_idle;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_idle    <= '0;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < SEL_CPUS; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            if (i_select_enable_we) begin
                r_enable <= i_select_enable;
            end
            if (in_accept) begin
                r_in_vld <= 1'b1;
            end else if (stage_adv) begin
                r_in_vld <= 1'b0;
            end
            if (stage_adv) begin
                r_idle <= n_idle;
                if (n_cnt_we) begin
                    r_count[cpu_idx] <= n_cnt;
                end
            end
            if (stage_adv && is_select) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_opcode  <= i_opcode;
            r_cpu     <= i_cpu_id;
            r_pref    <= i_preferred_set;
            r_prev    <= i_previous_cpu;
            r_single  <= i_single_cpu_only;
            r_sync    <= i_wake_sync;
            r_exiting <= i_waker_exiting;
        end
        if (stage_adv && is_select) begin
            r_tgt_vld <= n_tgt_vld;
            r_tgt_cpu <= n_tgt_cpu;
            r_kind    <= n_kind;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_target_valid = r_tgt_vld;
    assign o_wake_cpu     = r_tgt_cpu;
    assign o_choice_kind  = r_kind;

endmodule

/* rtl/icwts_checker.sv */
// ----------------------------------------------------------------------------
// icwts_checker
// Port-level checks for the idle cpu wake target selector, bound to the top.
// ----------------------------------------------------------------------------
module icwts_checker
    import icwts_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input logic                o_target_valid,
    input logic [CPU_ID_W-1:0] o_wake_cpu,
    input logic [KIND_W-1:0]   o_choice_kind
);

    // a stalled result is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // no target means zero cpu and no choice
    a_none_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_target_valid |-> o_wake_cpu == '0 && o_choice_kind == KIND_NONE)
        else $error("empty result carries a target");

    // a target always names how it was chosen
    a_kind_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_target_valid |-> o_choice_kind != KIND_NONE)
        else $error("target without choice kind");

endmodule

bind idle_cpu_wake_target_selector icwts_checker u_icwts_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_target_valid (o_target_valid),
    .o_wake_cpu     (o_wake_cpu),
    .o_choice_kind  (o_choice_kind)
);
